FILE: rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RECIP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV   = 3'd4;

endpackage

FILE: rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, reciprocal and divide in signed fixed
// point, with saturation, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Path: product stage, sum stage, then the one-bit-per-stage divider that
//   every word passes through, then the output register.
// Throughput: one word per cycle; the whole pipeline holds when the output
//   word is not taken.
// Reset: synchronous, active low; clears all valid bits, no payload reset.
module complex_arith_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]         in_tdata,
  // kind
  input  logic [cau_pkg::KIND_W-1:0]                in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // res_real, res_imag
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]         out_tdata,
  // div_by_zero, overflow
  output logic [1:0]                                out_tuser
);
  import cau_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * DW;
  localparam int XW  = 2 * DW + 1;
  localparam int NW  = 2 * DW + 2 * F;
  localparam int SNW = NW + 1;
  localparam int MW  = 2 * DW;
  localparam int TW  = 2 * XW + KIND_W + 3;
  localparam int OW  = ((2 * DW + 7) / 8) * 8;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // stage 1: products
  logic signed [DW-1:0] ar, ai, br, bi, xr, xi;
  logic [KIND_W-1:0]    kind;
  assign ar   = in_tdata[DW-1:0];
  assign ai   = in_tdata[2*DW-1:DW];
  assign br   = in_tdata[3*DW-1:2*DW];
  assign bi   = in_tdata[4*DW-1:3*DW];
  assign kind = in_tuser;
  assign xr   = (kind == KIND_RECIP) ? ar : br;
  assign xi   = (kind == KIND_RECIP) ? ai : bi;

  logic                 s1_vld_r;
  logic [KIND_W-1:0]    s1_kind_r;
  logic signed [DW-1:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;
  logic signed [PW-1:0] s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r, s1_p4_r, s1_p5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= kind;
      s1_ar_r   <= ar;
      s1_ai_r   <= ai;
      s1_br_r   <= br;
      s1_bi_r   <= bi;
      s1_p0_r   <= PW'(ar) * PW'(br);
      s1_p1_r   <= PW'(ai) * PW'(bi);
      s1_p2_r   <= PW'(ar) * PW'(bi);
      s1_p3_r   <= PW'(ai) * PW'(br);
      s1_p4_r   <= PW'(xr) * PW'(xr);
      s1_p5_r   <= PW'(xi) * PW'(xi);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: sums, squared magnitude, divider numerators
  logic signed [XW-1:0]  nd_re, nd_im, qn_re, qn_im;
  logic signed [SNW-1:0] num_re, num_im;
  logic [NW-1:0]         mag_re, mag_im;
  logic [MW-1:0]         mag2;
  logic                  dz;

  always_comb begin
    nd_re  = '0;
    nd_im  = '0;
    num_re = '0;
    num_im = '0;
    mag2   = MW'(s1_p4_r + s1_p5_r);
    qn_re  = XW'(s1_p0_r) + XW'(s1_p1_r);
    qn_im  = XW'(s1_p3_r) - XW'(s1_p2_r);
    dz     = 1'b0;
    case (s1_kind_r)
      KIND_ADD: begin
        nd_re = XW'(s1_ar_r) + XW'(s1_br_r);
        nd_im = XW'(s1_ai_r) + XW'(s1_bi_r);
      end
      KIND_SUB: begin
        nd_re = XW'(s1_ar_r) - XW'(s1_br_r);
        nd_im = XW'(s1_ai_r) - XW'(s1_bi_r);
      end
      KIND_MUL: begin
        nd_re = (XW'(s1_p0_r) - XW'(s1_p1_r)) >>> F;
        nd_im = (XW'(s1_p2_r) + XW'(s1_p3_r)) >>> F;
      end
      KIND_RECIP: begin
        num_re = SNW'(s1_ar_r) <<< (2 * F);
        num_im = -(SNW'(s1_ai_r) <<< (2 * F));
        dz     = (mag2 == '0);
      end
      KIND_DIV: begin
        num_re = SNW'(qn_re) <<< F;
        num_im = SNW'(qn_im) <<< F;
        dz     = (mag2 == '0);
      end
      default: begin
      end
    endcase
    mag_re = NW'(num_re[SNW-1] ? -num_re : num_re);
    mag_im = NW'(num_im[SNW-1] ? -num_im : num_im);
  end

  logic                 s2_vld_r;
  logic [NW-1:0]        s2_mag_re_r, s2_mag_im_r;
  logic [MW-1:0]        s2_mag2_r;
  logic [TW-1:0]        s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag_re_r <= mag_re;
      s2_mag_im_r <= mag_im;
      // zero divisor runs through as 1 to keep the divider quiet
      s2_mag2_r   <= dz ? MW'(1) : mag2;
      s2_tag_r    <= {num_im[SNW-1], num_re[SNW-1], dz, s1_kind_r, nd_im, nd_re};
    end
  end

  // --------------------------------------------------------------------------
  // divider
  logic                 dv_vld;
  logic [DW-1:0]        dv_q_re, dv_q_im;
  logic                 dv_big_re, dv_big_im;
  logic [TW-1:0]        dv_tag;

  cau_div #(
    .DW (DW),
    .NW (NW),
    .MW (MW),
    .TW (TW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .num_re    (s2_mag_re_r),
    .num_im    (s2_mag_im_r),
    .den       (s2_mag2_r),
    .tag_in    (s2_tag_r),
    .out_valid (dv_vld),
    .q_re      (dv_q_re),
    .q_im      (dv_q_im),
    .big_re    (dv_big_re),
    .big_im    (dv_big_im),
    .tag_out   (dv_tag)
  );

  // --------------------------------------------------------------------------
  // final stage: sign, saturate, output register
  logic signed [XW-1:0] t_nd_re, t_nd_im;
  logic [KIND_W-1:0]    t_kind;
  logic                 t_dz, t_neg_re, t_neg_im;
  assign {t_neg_im, t_neg_re, t_dz, t_kind, t_nd_im, t_nd_re} = dv_tag;

  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW+1:0] qs_re, qs_im;
  logic signed [XW-1:0] v_re, v_im;
  logic signed [DW-1:0] res_re, res_im;
  logic                 ovf_re, ovf_im, is_div;

  always_comb begin
    qs_re  = t_neg_re ? -$signed({2'b00, dv_q_re}) : $signed({2'b00, dv_q_re});
    qs_im  = t_neg_im ? -$signed({2'b00, dv_q_im}) : $signed({2'b00, dv_q_im});
    is_div = (t_kind == KIND_RECIP) || (t_kind == KIND_DIV);
    v_re   = is_div ? XW'(qs_re) : t_nd_re;
    v_im   = is_div ? XW'(qs_im) : t_nd_im;
    // out of range when the bits above the sign are not all sign copies
    ovf_re = (is_div && dv_big_re) ||
             (v_re[XW-1:DW-1] != {(XW-DW+1){v_re[XW-1]}});
    ovf_im = (is_div && dv_big_im) ||
             (v_im[XW-1:DW-1] != {(XW-DW+1){v_im[XW-1]}});
    res_re = v_re[DW-1:0];
    res_im = v_im[DW-1:0];
    if (ovf_re) begin
      res_re = (is_div ? t_neg_re : v_re[XW-1]) ? SMIN : SMAX;
    end
    if (ovf_im) begin
      res_im = (is_div ? t_neg_im : v_im[XW-1]) ? SMIN : SMAX;
    end
    if (is_div && t_dz) begin
      res_re = '0;
      res_im = '0;
      ovf_re = 1'b0;
      ovf_im = 1'b0;
    end
  end

  logic          out_vld_r;
  logic [OW-1:0] out_data_r;
  logic [1:0]    out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OW'({res_im, res_re});
      out_user_r <= {ovf_re || ovf_im, is_div && t_dz};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/core/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, two lanes sharing one divisor. One quotient
// bit per stage; a range check up front flags quotients of 2^DW or more.
// ----------------------------------------------------------------------------
module cau_div #(
  parameter int DW = 32,
  parameter int NW = 96,
  parameter int MW = 64,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num_re,
  input  logic [NW-1:0] num_im,
  input  logic [MW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [DW-1:0] q_re,
  output logic [DW-1:0] q_im,
  output logic          big_re,
  output logic          big_im,
  output logic [TW-1:0] tag_out
);

  localparam int CW = (NW > 3 * DW) ? NW : 3 * DW;

  logic          vld_r   [0:DW];
  logic [CW-1:0] r_re_r  [0:DW];
  logic [CW-1:0] r_im_r  [0:DW];
  logic [MW-1:0] den_r   [0:DW];
  logic [DW-1:0] q_re_r  [0:DW];
  logic [DW-1:0] q_im_r  [0:DW];
  logic          big_re_r[0:DW];
  logic          big_im_r[0:DW];
  logic [TW-1:0] tag_r   [0:DW];

  logic [CW-1:0] den_top;
  assign den_top = CW'(den) << DW;

  // stage 0: range check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_re_r[0]   <= CW'(num_re);
      r_im_r[0]   <= CW'(num_im);
      den_r[0]    <= den;
      q_re_r[0]   <= '0;
      q_im_r[0]   <= '0;
      big_re_r[0] <= CW'(num_re) >= den_top;
      big_im_r[0] <= CW'(num_im) >= den_top;
      tag_r[0]    <= tag_in;
    end
  end

  for (genvar s = 0; s < DW; s++) begin : g_step
    localparam int B = DW - 1 - s;
    logic [CW-1:0] dsh;
    logic          ge_re, ge_im;
    logic [DW-1:0] q_re_nxt, q_im_nxt;

    always_comb begin
      dsh      = CW'(den_r[s]) << B;
      ge_re    = r_re_r[s] >= dsh;
      ge_im    = r_im_r[s] >= dsh;
      q_re_nxt = q_re_r[s];
      q_im_nxt = q_im_r[s];
      q_re_nxt[B] = ge_re;
      q_im_nxt[B] = ge_im;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_re_r[s+1]   <= ge_re ? r_re_r[s] - dsh : r_re_r[s];
        r_im_r[s+1]   <= ge_im ? r_im_r[s] - dsh : r_im_r[s];
        den_r[s+1]    <= den_r[s];
        q_re_r[s+1]   <= q_re_nxt;
        q_im_r[s+1]   <= q_im_nxt;
        big_re_r[s+1] <= big_re_r[s];
        big_im_r[s+1] <= big_im_r[s];
        tag_r[s+1]    <= tag_r[s];
      end
    end
  end

  assign out_valid = vld_r[DW];
  assign q_re      = q_re_r[DW];
  assign q_im      = q_im_r[DW];
  assign big_re    = big_re_r[DW];
  assign big_im    = big_im_r[DW];
  assign tag_out   = tag_r[DW];

endmodule

FILE: rtl/core/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks for the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  input logic [1:0]                          out_tuser
);

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // zero divisor gives a zero word and no overflow
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("divide by zero word not clean");

  // input is stalled only behind a stalled output word
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without backpressure");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: test/complex_arith_unit_tb.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_tb
// Streams complex operand words through the unit, mostly with random gaps on
// both sides, and checks every result word against a fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arith_unit_tb;
  import cau_pkg::*;

  localparam int FB = 16;
  localparam int DW = 32;
  localparam int LATENCY = DW + 4;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 ovf;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [4*DW-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*DW-1:0] out_tdata;
  logic [1:0] out_tuser;

  cplx_res_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit timed_out = 0;
  bit rx_stall_on = 1;

  complex_arith_unit #(.FRAC_BITS(FB), .DATA_WIDTH(DW)) dut (.*);

  always #10 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [DW-1:0] saturate(logic signed [127:0] x, ref logic ovf);
    logic signed [127:0] hi_lim, lo_lim;
    hi_lim = (128'sd1 <<< (DW - 1)) - 1;
    lo_lim = -(128'sd1 <<< (DW - 1));
    if (x > hi_lim) begin
      ovf = 1'b1;
      return hi_lim[DW-1:0];
    end
    if (x < lo_lim) begin
      ovf = 1'b1;
      return lo_lim[DW-1:0];
    end
    return x[DW-1:0];
  endfunction

  // signed numerator over positive denominator, truncated toward zero
  function automatic logic signed [127:0] quot_trunc(logic signed [127:0] n,
                                                     logic signed [127:0] d);
    logic [127:0] mag;
    logic [127:0] q;
    mag = n[127] ? -n : n;
    q = mag / d;
    return n[127] ? -q : q;
  endfunction

  function automatic cplx_res_t complex_predict(logic [KIND_W-1:0] kind,
                                                logic signed [DW-1:0] ar,
                                                logic signed [DW-1:0] ai,
                                                logic signed [DW-1:0] br,
                                                logic signed [DW-1:0] bi);
    logic signed [127:0] xr, xi, yr, yi, re, im, m, nr, ni;
    cplx_res_t r;
    logic ovf;
    xr = ar; xi = ai; yr = br; yi = bi;
    re = 0; im = 0; ovf = 1'b0;
    r.dz = 1'b0;
    case (kind)
      KIND_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      KIND_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      KIND_MUL: begin
        re = (xr * yr - xi * yi) >>> FB;
        im = (xr * yi + xi * yr) >>> FB;
      end
      KIND_RECIP: begin
        m = xr * xr + xi * xi;
        if (m == 0) r.dz = 1'b1;
        else begin
          re = quot_trunc(xr <<< (2 * FB), m);
          im = quot_trunc(-(xi <<< (2 * FB)), m);
        end
      end
      KIND_DIV: begin
        m = yr * yr + yi * yi;
        if (m == 0) r.dz = 1'b1;
        else begin
          nr = xr * yr + xi * yi;
          ni = xi * yr - xr * yi;
          re = quot_trunc(nr <<< FB, m);
          im = quot_trunc(ni <<< FB, m);
        end
      end
      default: ;
    endcase
    r.re = saturate(re, ovf);
    r.im = saturate(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  task automatic send_word(logic [KIND_W-1:0] kind, logic [DW-1:0] ar, logic [DW-1:0] ai,
                           logic [DW-1:0] br, logic [DW-1:0] bi);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tuser <= kind;
    in_tdata <= {bi, br, ai, ar};
    in_tvalid <= 1'b1;
    expected_q.push_back(complex_predict(kind, ar, ai, br, bi));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return $urandom_range(0, 3) << FB;
      3: return -($urandom_range(0, 3) << FB);
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      5: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0 && !timed_out) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [DW-1:0] mx, mn, one;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    one = 1 << FB;
    send_word(KIND_ADD, mx, mn, mx, mn);       // both parts saturate
    send_word(KIND_ADD, 32'hFFFF_FFFF, 0, 1, 0);
    send_word(KIND_SUB, mn, mx, mx, mn);
    send_word(KIND_SUB, 5, -5, 5, -5);
    send_word(KIND_MUL, mx, mx, mx, mx);
    send_word(KIND_MUL, mn, mn, mn, mn);
    send_word(KIND_MUL, one, one, -one, one);
    send_word(KIND_MUL, -1, -1, 1, 0);          // floor shift
    send_word(KIND_RECIP, 0, 0, one, one);      // zero divisor
    send_word(KIND_RECIP, one, one, 0, 0);
    send_word(KIND_RECIP, 1, 0, 7, 7);          // huge result
    send_word(KIND_RECIP, mn, mn, 0, 0);
    send_word(KIND_RECIP, -3 * one, 2, mx, mn); // b ignored
    send_word(KIND_DIV, one, one, 0, 0);        // zero divisor
    send_word(KIND_DIV, mx, mn, 1, 0);
    send_word(KIND_DIV, -7, 3, 2 * one, -one);
    send_word(KIND_DIV, mn, mn, mn, mn);
    send_word(KIND_DIV, mx, mx, mx, mx);
    send_word(3'd5, mx, mx, mx, mx);            // unknown kinds
    send_word(3'd6, mn, 1, 1, 1);
    send_word(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(int n);
    logic [KIND_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 19) == 0) ? KIND_W'($urandom_range(5, 7))
                                        : KIND_W'($urandom_range(0, 4));
      send_word(k, rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  task automatic test_back_to_back(int n);
    rx_stall_on = 0;
    for (int i = 0; i < n; i++) begin
      in_tuser <= KIND_W'($urandom_range(0, 7));
      in_tdata <= {$urandom(), $urandom(), $urandom(), $urandom()};
      in_tvalid <= 1'b1;
      @(posedge clk);
      expected_q.push_back(complex_predict(in_tuser, in_tdata[DW-1:0], in_tdata[2*DW-1:DW],
                                           in_tdata[3*DW-1:2*DW], in_tdata[4*DW-1:3*DW]));
      while (!in_tready) begin
        @(posedge clk);
      end
      @(negedge clk);
    end
    rx_stall_on = 1;
  endtask

  // receiver: random stalls, checks each word against the oldest prediction
  always @(negedge clk) begin
    if (!rst_n || !rx_stall_on) begin
      rx_hold = 0;
      out_tready <= rst_n;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rx_hold = gap_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cplx_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h/%b", out_tdata, out_tuser);
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[DW-1:0] !== e.re || out_tdata[2*DW-1:DW] !== e.im ||
            out_tuser[0] !== e.dz || out_tuser[1] !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp re=%h im=%h dz=%b ovf=%b got re=%h im=%h dz=%b ovf=%b",
                     e.re, e.im, e.dz, e.ovf, out_tdata[DW-1:0], out_tdata[2*DW-1:DW],
                     out_tuser[0], out_tuser[1]);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("complex_arith_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_random(900);
    wait_drained();
    test_back_to_back(100);
    test_random(930);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("complex_arith_unit verification clean");
    else
      $display("complex_arith_unit verification failed");
    $finish;
  end

endmodule

FILE: complex_arith_unit.f
rtl/core/cau_pkg.sv
rtl/core/cau_div.sv
rtl/core/complex_arith_unit.sv
rtl/core/cau_checker.sv
test/complex_arith_unit_tb.sv
